/* rtl/core/bfm_pkg.sv */
// Shared types, codes and constants of the Bloom filter bank.
package bfm_pkg;

   localparam int DEF_NUM_FILTERS     = 4;
   localparam int DEF_MAX_FILTER_BITS = 65536;
   localparam int DEF_MAX_KEY_BYTES   = 64;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
   localparam int          MIX_SHIFT = 47;

   localparam int CSR_DATA_W = 17;

   localparam logic [6:0]  RST_KEY_BYTES   = 7'd32;
   localparam logic [4:0]  RST_HASH_COUNT  = 5'd3;
   localparam logic [16:0] RST_FILTER_BITS = 17'd65536;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_LOAD   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_KEY_BYTES   = 2'd0,
      CSR_HASH_COUNT  = 2'd1,
      CSR_FILTER_BITS = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   // One unit of work handed from the front to the back.
   typedef struct packed {
      logic        is_load;
      logic        is_query;
      logic [1:0]  sel;
      logic [12:0] offset;
      logic [7:0]  data;
   } job_type;

endpackage

/* rtl/core/bfm_queue.sv */
// Short request queue between the front and the back.
module bfm_queue
   import bfm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/bfm_front.sv */
// Front end: accepts requests, gathers key words and queues jobs.
module bfm_front
   import bfm_pkg::*;
#(
   parameter int LEN_W = 7,
   parameter int KW_AW = 3,
   parameter int KEY_WORDS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_cmd,
   input  logic [1:0]       req_filter_select,
   input  logic [63:0]      req_key_word,
   input  logic [7:0]       req_load_byte,
   input  logic [12:0]      req_byte_offset,
   input  logic [LEN_W-1:0] len,
   input  logic             key_release,
   input  logic             back_ready,
   input  logic             q_full,
   output logic             q_push,
   output job_type          q_data,
   input  logic [KW_AW-1:0] kb_raddr,
   output logic [63:0]      kb_rdata
);

   logic [63:0]      key_mem [KEY_WORDS];
   logic [63:0]      kb_rdata_ff;
   logic [KW_AW-1:0] wc_ff, wc_in;
   logic             key_busy_ff, key_busy_in;
   logic             accept, is_key, is_load, last;
   logic [LEN_W:0]   needed;

   assign req_full = q_full || key_busy_ff || !back_ready;
   assign accept   = req_push && !req_full;
   assign is_key   = (req_cmd == CMD_INSERT) || (req_cmd == CMD_QUERY);
   assign is_load  = (req_cmd == CMD_LOAD);
   assign needed   = ({1'b0, len} + (LEN_W+1)'(7)) >> 3;
   assign last     = ((LEN_W+1)'(wc_ff) + (LEN_W+1)'(1)) >= needed;
   assign kb_rdata = kb_rdata_ff;

   assign q_push          = accept && (is_load || (is_key && last));
   assign q_data.is_load  = is_load;
   assign q_data.is_query = (req_cmd == CMD_QUERY);
   assign q_data.sel      = req_filter_select;
   assign q_data.offset   = req_byte_offset;
   assign q_data.data     = req_load_byte;

   always_comb begin
      wc_in       = wc_ff;
      key_busy_in = key_busy_ff;
      if (key_release) begin
         key_busy_in = 1'b0;
      end
      if (accept && is_key) begin
         if (last) begin
            wc_in       = '0;
            key_busy_in = 1'b1;
         end else begin
            wc_in = wc_ff + KW_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_key) begin
         key_mem[wc_ff] <= req_key_word;
      end
      kb_rdata_ff <= key_mem[kb_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff       <= '0;
         key_busy_ff <= 1'b0;
      end else begin
         wc_ff       <= wc_in;
         key_busy_ff <= key_busy_in;
      end
   end

endmodule

/* rtl/core/bfm_hash.sv */
// Sequenced MurmurHash64A unit with a bit-serial reduction modulo the filter size.
module bfm_hash
   import bfm_pkg::*;
#(
   parameter int KEY_WORDS = 8,
   parameter int KW_AW = 3,
   parameter int LEN_W = 7,
   parameter int FB_W = 17,
   parameter int POS_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [4:0]       seed,
   input  logic [LEN_W-1:0] len,
   input  logic [FB_W-1:0]  fb,
   output logic [KW_AW-1:0] kb_raddr,
   input  logic [63:0]      kb_rdata,
   output logic             done,
   output logic [POS_W-1:0] pos
);

   localparam int IDX_W = $clog2(KEY_WORDS + 1);

   typedef enum logic [6:0] {
      H_IDLE = 7'b0000001,
      H_MUL  = 7'b0000010,
      H_POST = 7'b0000100,
      H_WORD = 7'b0001000,
      H_KEY  = 7'b0010000,
      H_TAIL = 7'b0100000,
      H_DIV  = 7'b1000000
   } hstate_type;

   typedef enum logic [5:0] {
      P_LEN  = 6'b000001,
      P_K1   = 6'b000010,
      P_K2   = 6'b000100,
      P_H    = 6'b001000,
      P_TAIL = 6'b010000,
      P_F1   = 6'b100000
   } phase_type;

   hstate_type       state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [63:0]      h_ff, h_in;
   logic [63:0]      a_ff, a_in;
   logic [63:0]      acc_ff, acc_in;
   logic [1:0]       mstep_ff, mstep_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [FB_W-1:0]  rem_ff, rem_in;
   logic             done_ff, done_in;
   logic [31:0]      op_a, op_b;
   logic [63:0]      prod, acc_mix, h_mix, tail_mask, tail_word;
   logic [FB_W:0]    rem_sh;
   logic [2:0]       tail;

   assign tail = len[2:0];
   assign op_a = (mstep_ff == 2'd2) ? a_ff[63:32] : a_ff[31:0];
   assign op_b = (mstep_ff == 2'd1) ? MIX_MUL[63:32] : MIX_MUL[31:0];
   assign prod = op_a * op_b;
   assign acc_mix = acc_ff ^ (acc_ff >> MIX_SHIFT);
   assign h_mix   = h_ff ^ (h_ff >> MIX_SHIFT);
   assign rem_sh  = {rem_ff, h_ff[63]};
   assign kb_raddr = idx_ff[KW_AW-1:0];
   assign done = done_ff;
   assign pos  = rem_ff[POS_W-1:0];

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         tail_mask[8*j +: 8] = (3'(j) < tail) ? 8'hff : 8'h00;
      end
   end

   assign tail_word = h_ff ^ (kb_rdata & tail_mask);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      h_in     = h_ff;
      a_in     = a_ff;
      acc_in   = acc_ff;
      mstep_in = mstep_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               a_in     = 64'(len);
               phase_in = P_LEN;
               mstep_in = 2'd0;
               state_in = H_MUL;
            end
         end
         H_MUL: begin
            // Low 64 bits of a 64x64 product from three 32x32 partial products.
            if (mstep_ff == 2'd0) begin
               acc_in = prod;
            end else begin
               acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
            end
            if (mstep_ff == 2'd2) begin
               mstep_in = 2'd0;
               state_in = H_POST;
            end else begin
               mstep_in = mstep_ff + 2'd1;
            end
         end
         H_POST: begin
            unique case (phase_ff)
               P_LEN: begin
                  h_in     = 64'(seed) ^ acc_ff;
                  idx_in   = '0;
                  state_in = H_WORD;
               end
               P_K1: begin
                  a_in     = acc_mix;
                  phase_in = P_K2;
                  state_in = H_MUL;
               end
               P_K2: begin
                  a_in     = h_ff ^ acc_ff;
                  phase_in = P_H;
                  state_in = H_MUL;
               end
               P_H: begin
                  h_in     = acc_ff;
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = H_WORD;
               end
               P_TAIL: begin
                  h_in     = acc_ff;
                  a_in     = acc_mix;
                  phase_in = P_F1;
                  state_in = H_MUL;
               end
               P_F1: begin
                  h_in     = acc_mix;
                  cnt_in   = '0;
                  rem_in   = '0;
                  state_in = H_DIV;
               end
               default: begin
                  state_in = H_IDLE;
               end
            endcase
         end
         H_WORD: begin
            if (32'(idx_ff) < 32'(len >> 3)) begin
               state_in = H_KEY;
            end else if (tail != 3'd0) begin
               state_in = H_TAIL;
            end else begin
               a_in     = h_mix;
               phase_in = P_F1;
               state_in = H_MUL;
            end
         end
         H_KEY: begin
            a_in     = kb_rdata;
            phase_in = P_K1;
            state_in = H_MUL;
         end
         H_TAIL: begin
            h_in     = tail_word;
            a_in     = tail_word;
            phase_in = P_TAIL;
            state_in = H_MUL;
         end
         H_DIV: begin
            // Restoring reduction, one hash bit per cycle, most significant first.
            if (rem_sh >= {1'b0, fb}) begin
               rem_in = FB_W'(rem_sh - {1'b0, fb});
            end else begin
               rem_in = rem_sh[FB_W-1:0];
            end
            h_in   = {h_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               done_in  = 1'b1;
               state_in = H_IDLE;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      h_ff     <= h_in;
      a_ff     <= a_in;
      acc_ff   <= acc_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      phase_ff <= phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         mstep_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mstep_ff <= mstep_in;
         done_ff  <= done_in;
      end
   end

endmodule

/* rtl/core/bfm_back.sv */
// Back end: filter memory with clearing pass, seed loop and result register.
module bfm_back
   import bfm_pkg::*;
#(
   parameter int NUM_FILTERS = 4,
   parameter int FILTER_BYTES = 8192,
   parameter int ADDR_W = 15,
   parameter int POS_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  job_type          job,
   output logic             job_pop,
   input  logic [4:0]       hash_count,
   output logic             hash_start,
   output logic [4:0]       hash_seed,
   input  logic             hash_done,
   input  logic [POS_W-1:0] hash_pos,
   output logic             key_release,
   output logic             ready,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic             rsp_result_kind,
   output logic             rsp_present,
   output logic [1:0]       rsp_filter_echo
);

   localparam int DEPTH = NUM_FILTERS * FILTER_BYTES;

   typedef enum logic [6:0] {
      B_CLEAR  = 7'b0000001,
      B_IDLE   = 7'b0000010,
      B_NEXT   = 7'b0000100,
      B_HASH   = 7'b0001000,
      B_READ   = 7'b0010000,
      B_CHECK  = 7'b0100000,
      B_REPORT = 7'b1000000
   } bstate_type;

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_ff;
   bstate_type        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [2:0]        bit_ff, bit_in;
   logic [4:0]        seed_ff, seed_in;
   logic              query_ff, query_in;
   logic [1:0]        sel_ff, sel_in;
   logic              all_ff, all_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic              out_present_ff, out_present_in;
   logic [1:0]        out_sel_ff, out_sel_in;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [7:0]        wdata;
   logic              job_exists, cur_exists, load_ok, bit_set;
   logic [ADDR_W-1:0] load_addr, hash_addr;

   assign job_exists = 32'(job.sel) < NUM_FILTERS;
   assign cur_exists = 32'(sel_ff) < NUM_FILTERS;
   assign load_ok    = job_exists && (32'(job.offset) < FILTER_BYTES);
   assign load_addr  = ADDR_W'(32'(job.sel) * FILTER_BYTES + 32'(job.offset));
   assign hash_addr  = ADDR_W'(32'(sel_ff) * FILTER_BYTES + 32'(hash_pos >> 3));
   assign bit_set    = rd_ff[bit_ff];

   assign ready           = (state_ff != B_CLEAR);
   assign hash_seed       = seed_ff;
   assign rsp_empty       = !out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_present     = out_present_ff;
   assign rsp_filter_echo = out_sel_ff;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      addr_in        = addr_ff;
      bit_in         = bit_ff;
      seed_in        = seed_ff;
      query_in       = query_ff;
      sel_in         = sel_ff;
      all_in         = all_ff;
      out_valid_in   = out_valid_ff && !rsp_pop;
      out_kind_in    = out_kind_ff;
      out_present_in = out_present_ff;
      out_sel_in     = out_sel_ff;
      we             = 1'b0;
      waddr          = load_addr;
      wdata          = job.data;
      job_pop        = 1'b0;
      hash_start     = 1'b0;
      key_release    = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            wdata = 8'h00;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               if (job.is_load) begin
                  we = load_ok;
               end else begin
                  query_in = job.is_query;
                  sel_in   = job.sel;
                  seed_in  = '0;
                  all_in   = 1'b1;
                  state_in = B_NEXT;
               end
            end
         end
         B_NEXT: begin
            if (!cur_exists) begin
               all_in   = 1'b0;
               state_in = B_REPORT;
            end else if (seed_ff == hash_count) begin
               state_in = B_REPORT;
            end else begin
               hash_start = 1'b1;
               state_in   = B_HASH;
            end
         end
         B_HASH: begin
            if (hash_done) begin
               addr_in  = hash_addr;
               bit_in   = hash_pos[2:0];
               state_in = B_READ;
            end
         end
         B_READ: begin
            state_in = B_CHECK;
         end
         B_CHECK: begin
            if (!query_ff) begin
               we       = 1'b1;
               waddr    = addr_ff;
               wdata    = rd_ff | (8'h01 << bit_ff);
               seed_in  = seed_ff + 5'd1;
               state_in = B_NEXT;
            end else if (!bit_set) begin
               all_in   = 1'b0;
               state_in = B_REPORT;
            end else begin
               seed_in  = seed_ff + 5'd1;
               state_in = B_NEXT;
            end
         end
         B_REPORT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in   = 1'b1;
               out_kind_in    = query_ff;
               out_present_in = query_ff && all_ff;
               out_sel_in     = sel_ff;
               key_release    = 1'b1;
               state_in       = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      bit_ff         <= bit_in;
      seed_ff        <= seed_in;
      query_ff       <= query_in;
      sel_ff         <= sel_in;
      all_ff         <= all_in;
      out_kind_ff    <= out_kind_in;
      out_present_ff <= out_present_in;
      out_sel_ff     <= out_sel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* rtl/core/bloom_filter_murmur64a.sv */
// Keys: after its last word, a key is hashed at most once for each seed below hash_count, with
// one 32x32 multiplier building each 64-bit product and a bit-serial reduction modulo the
// filter size. A load is written in the back when it is popped; cmd 3 is dropped.
// Throughput: one request per cycle while no key is being hashed; a completed key holds off
// further requests until its result is registered. A finished result waits in its own register.
// Reset: synchronous; then a clearing pass zeroes all filter memory, holding off requests.
module bloom_filter_murmur64a
   import bfm_pkg::*;
#(
   parameter int NUM_FILTERS     = DEF_NUM_FILTERS,
   parameter int MAX_FILTER_BITS = DEF_MAX_FILTER_BITS,
   parameter int MAX_KEY_BYTES   = DEF_MAX_KEY_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_cmd,
   input  logic [1:0]            req_filter_select,
   input  logic [63:0]           req_key_word,
   input  logic [7:0]            req_load_byte,
   input  logic [12:0]           req_byte_offset,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_result_kind,
   output logic                  rsp_present,
   output logic [1:0]            rsp_filter_echo,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int KEY_WORDS    = (MAX_KEY_BYTES + 7) / 8;
   localparam int KW_AW        = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam int LEN_W        = $clog2(MAX_KEY_BYTES + 1);
   localparam int FB_W         = $clog2(MAX_FILTER_BITS + 1);
   localparam int POS_W        = $clog2(MAX_FILTER_BITS);
   localparam int FILTER_BYTES = (MAX_FILTER_BITS + 7) / 8;
   localparam int ADDR_W       = (NUM_FILTERS * FILTER_BYTES > 1) ?
                                 $clog2(NUM_FILTERS * FILTER_BYTES) : 1;

   logic [6:0]       key_bytes_ff;
   logic [4:0]       hash_count_ff;
   logic [16:0]      filter_bits_ff;
   logic [LEN_W-1:0] eff_len;
   logic [FB_W-1:0]  eff_fb;
   logic             csr_write;

   logic             q_push, q_full, q_pop, q_empty;
   job_type          q_in, q_out;
   logic             key_release, back_ready;
   logic [KW_AW-1:0] kb_raddr;
   logic [63:0]      kb_rdata;
   logic             hash_start, hash_done;
   logic [4:0]       hash_seed;
   logic [POS_W-1:0] hash_pos;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff   <= RST_KEY_BYTES;
         hash_count_ff  <= RST_HASH_COUNT;
         filter_bits_ff <= RST_FILTER_BITS;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_BYTES:   key_bytes_ff   <= csr_wdata[6:0];
            CSR_HASH_COUNT:  hash_count_ff  <= csr_wdata[4:0];
            CSR_FILTER_BITS: filter_bits_ff <= csr_wdata[16:0];
            default: begin
            end
         endcase
      end
   end

   // Out-of-range sizes are clamped into the range the hardware supports.
   always_comb begin
      if (key_bytes_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (32'(key_bytes_ff) > MAX_KEY_BYTES) begin
         eff_len = LEN_W'(MAX_KEY_BYTES);
      end else begin
         eff_len = LEN_W'(key_bytes_ff);
      end
      if (filter_bits_ff == '0) begin
         eff_fb = FB_W'(1);
      end else if (32'(filter_bits_ff) > MAX_FILTER_BITS) begin
         eff_fb = FB_W'(MAX_FILTER_BITS);
      end else begin
         eff_fb = FB_W'(filter_bits_ff);
      end
   end

   bfm_front #(
      .LEN_W     (LEN_W),
      .KW_AW     (KW_AW),
      .KEY_WORDS (KEY_WORDS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_filter_select (req_filter_select),
      .req_key_word      (req_key_word),
      .req_load_byte     (req_load_byte),
      .req_byte_offset   (req_byte_offset),
      .len               (eff_len),
      .key_release       (key_release),
      .back_ready        (back_ready),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_data            (q_in),
      .kb_raddr          (kb_raddr),
      .kb_rdata          (kb_rdata)
   );

   bfm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   bfm_hash #(
      .KEY_WORDS (KEY_WORDS),
      .KW_AW     (KW_AW),
      .LEN_W     (LEN_W),
      .FB_W      (FB_W),
      .POS_W     (POS_W)
   ) u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .seed     (hash_seed),
      .len      (eff_len),
      .fb       (eff_fb),
      .kb_raddr (kb_raddr),
      .kb_rdata (kb_rdata),
      .done     (hash_done),
      .pos      (hash_pos)
   );

   bfm_back #(
      .NUM_FILTERS  (NUM_FILTERS),
      .FILTER_BYTES (FILTER_BYTES),
      .ADDR_W       (ADDR_W),
      .POS_W        (POS_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (!q_empty),
      .job             (q_out),
      .job_pop         (q_pop),
      .hash_count      (hash_count_ff),
      .hash_start      (hash_start),
      .hash_seed       (hash_seed),
      .hash_done       (hash_done),
      .hash_pos        (hash_pos),
      .key_release     (key_release),
      .ready           (back_ready),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_result_kind (rsp_result_kind),
      .rsp_present     (rsp_present),
      .rsp_filter_echo (rsp_filter_echo)
   );

endmodule

/* rtl/core/bfm_checker.sv */
// Port-level checks of the Bloom filter bank and their binding to the top level.
module bfm_checker
   import bfm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_result_kind,
   input logic       rsp_present,
   input logic [1:0] rsp_filter_echo
);

   // The clearing pass holds off requests right after reset.
   a_full_after_reset: assert property (@(posedge clock) reset |=> req_full)
      else $error("request side open right after reset");

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   a_insert_not_present: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_result_kind) |-> !rsp_present)
      else $error("insert result reports present");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_result_kind)
         && $stable(rsp_present) && $stable(rsp_filter_echo)))
      else $error("waiting result changed or vanished");

endmodule

bind bloom_filter_murmur64a bfm_checker u_bfm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_result_kind (rsp_result_kind),
   .rsp_present     (rsp_present),
   .rsp_filter_echo (rsp_filter_echo)
);
